// ----- rtl/core/uv_sphere_vertex_generator_assert.svh -----
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Shorthand for clocked implication checks with reset gating.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define UVS_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("uvs: assertion failed");

// consequent checked in the cycle after the antecedent
`define UVS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("uvs: assertion failed");

`endif

// ----- rtl/core/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, pipeline depths, Horner constants and item types.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned MAX_DIVISIONS = 255;

  localparam int unsigned CNT_W      = 8;
  localparam int unsigned RAD_W      = 16;
  localparam int unsigned IDX_IN_W   = 8;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned VTX_W      = 17;
  localparam int unsigned DEN_W      = CNT_W + 1;
  localparam int unsigned PH_W       = 32;
  localparam int unsigned TRIG_W     = FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0] STACKS_RST = 8'd16;
  localparam logic [CNT_W-1:0] SLICES_RST = 8'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'b00,
    CFG_STACKS = 2'b01,
    CFG_SLICES = 2'b10
  } cfg_reg_t;

  // Q2.30 trig arithmetic
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int unsigned SIN_TERMS = 6;
  localparam int unsigned COS_TERMS = 7;

  // Horner divisors; x / d == (x * M) >> K exactly for any 32-bit x
  localparam int unsigned SIN_K [SIN_TERMS] = '{35, 37, 38, 39, 39, 40};
  localparam int unsigned COS_K [COS_TERMS] = '{33, 36, 37, 38, 39, 40, 40};

  localparam logic [32:0] SIN_M [SIN_TERMS] = '{
    33'(((64'd1 << 35) + 64'd5) / 64'd6),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 40) + 64'd155) / 64'd156)
  };

  localparam logic [32:0] COS_M [COS_TERMS] = '{
    33'(((64'd1 << 33) + 64'd1) / 64'd2),
    33'(((64'd1 << 36) + 64'd11) / 64'd12),
    33'(((64'd1 << 37) + 64'd29) / 64'd30),
    33'(((64'd1 << 38) + 64'd55) / 64'd56),
    33'(((64'd1 << 39) + 64'd89) / 64'd90),
    33'(((64'd1 << 40) + 64'd131) / 64'd132),
    33'(((64'd1 << 40) + 64'd181) / 64'd182)
  };

  // pipeline depths
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         = PH_W / DIV_BITS_PER_STAGE;
  localparam int unsigned HORNER_STAGES      = 2 * COS_TERMS;
  localparam int unsigned TRIG_STAGES        = 2 + HORNER_STAGES + 1;
  localparam int unsigned SCALE_STAGES       = 2;
  localparam int unsigned LAST_STAGE         = DIV_STAGES + TRIG_STAGES + SCALE_STAGES;

  typedef struct packed {
    logic             tri_valid;
    logic [VTX_W-1:0] index_a;
    logic [VTX_W-1:0] index_b;
    logic [VTX_W-1:0] index_c;
    logic [VTX_W-1:0] index_d;
    logic [VTX_W-1:0] index_e;
    logic [VTX_W-1:0] index_f;
  } idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    idx_t                    idx;
  } out_item_t;

  typedef struct packed {
    logic [TRIG_W-1:0] sin_mag;
    logic              sin_neg;
    logic [TRIG_W-1:0] cos_mag;
    logic              cos_neg;
  } trig_t;

endpackage

// ----- rtl/core/uvs_if.sv -----
// ----------------------------------------------------------------------------
// uvs_in_if / uvs_out_if
// Valid/ready channels for grid point items and vertex result items.
// ----------------------------------------------------------------------------
interface uvs_in_if;
  logic                           valid;
  logic                           ready;
  logic [uvs_pkg::IDX_IN_W-1:0]   stack_index;
  logic [uvs_pkg::IDX_IN_W-1:0]   slice_index;

  modport source (output valid, output stack_index, output slice_index, input ready);
  modport sink   (input valid, input stack_index, input slice_index, output ready);
endinterface

interface uvs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [uvs_pkg::POS_W-1:0] pos_x;
  logic signed [uvs_pkg::POS_W-1:0] pos_y;
  logic signed [uvs_pkg::POS_W-1:0] pos_z;
  logic                             tri_valid;
  logic [uvs_pkg::VTX_W-1:0]        index_a;
  logic [uvs_pkg::VTX_W-1:0]        index_b;
  logic [uvs_pkg::VTX_W-1:0]        index_c;
  logic [uvs_pkg::VTX_W-1:0]        index_d;
  logic [uvs_pkg::VTX_W-1:0]        index_e;
  logic [uvs_pkg::VTX_W-1:0]        index_f;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output tri_valid, output index_a, output index_b, output index_c,
                  output index_d, output index_e, output index_f, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input tri_valid, input index_a, input index_b, input index_c,
                  input index_d, input index_e, input index_f, output ready);
endinterface

// ----- rtl/core/uvs_div.sv -----
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider: phase = round(num * 2^32 / den), mod 2^32.
// ----------------------------------------------------------------------------
module uvs_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [uvs_pkg::CNT_W-1:0]   num,
  input  logic [uvs_pkg::DEN_W-1:0]   den,
  output logic [uvs_pkg::PH_W-1:0]    phase
);
  import uvs_pkg::*;

  logic [DEN_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [CNT_W-1:0] h_r   [DIV_STAGES];
  logic [PH_W-1:0]  q_r   [DIV_STAGES];

  logic [DEN_W-1:0] rem_nxt [DIV_STAGES];
  logic [PH_W-1:0]  q_nxt   [DIV_STAGES];

  always_comb begin : div_steps
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] dv;
    logic [PH_W-1:0]  hx;
    logic [PH_W-1:0]  q;
    logic [DEN_W:0]   trial;
    for (int st = 0; st < DIV_STAGES; st++) begin
      if (st == 0) begin
        // num never exceeds den; num == den is a full turn and wraps to 0
        rem = (DEN_W'(num) == den) ? '0 : DEN_W'(num);
        dv  = den;
        hx  = PH_W'(den >> 1);
        q   = '0;
      end else begin
        rem = rem_r[st-1];
        dv  = den_r[st-1];
        hx  = PH_W'(h_r[st-1]);
        q   = q_r[st-1];
      end
      for (int u = 0; u < DIV_BITS_PER_STAGE; u++) begin
        trial = {rem, hx[PH_W-1-(st*DIV_BITS_PER_STAGE+u)]};
        if (trial >= {1'b0, dv}) begin
          rem = DEN_W'(trial - {1'b0, dv});
          q   = {q[PH_W-2:0], 1'b1};
        end else begin
          rem = trial[DEN_W-1:0];
          q   = {q[PH_W-2:0], 1'b0};
        end
      end
      rem_nxt[st] = rem;
      q_nxt[st]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < DIV_STAGES; st++) begin
        rem_r[st] <= rem_nxt[st];
        q_r[st]   <= q_nxt[st];
        den_r[st] <= (st == 0) ? den : den_r[(st == 0) ? 0 : st-1];
        h_r[st]   <= (st == 0) ? CNT_W'(den >> 1) : h_r[(st == 0) ? 0 : st-1];
      end
    end
  end

  assign phase = q_r[DIV_STAGES-1];

endmodule

// ----- rtl/core/uvs_trig.sv -----
// ----------------------------------------------------------------------------
// uvs_trig
// Sine and cosine of a phase in turns: quadrant fold, Taylor series by
// Horner steps (multiply stage, reciprocal divide stage), Q1.16 rounding.
// ----------------------------------------------------------------------------
module uvs_trig (
  input  logic                       clk,
  input  logic                       en,
  input  logic [uvs_pkg::PH_W-1:0]   phase,
  output uvs_pkg::trig_t             trig
);
  import uvs_pkg::*;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  function automatic logic [31:0] one_minus(input logic [31:0] x);
    return (x >= 32'(Q30_ONE)) ? 32'd0 : 32'(Q30_ONE) - x;
  endfunction

  function automatic logic [TRIG_W-1:0] to_frac(input logic [31:0] v);
    logic [31:0] vc;
    logic [32:0] sum;
    vc  = (v > 32'(Q30_ONE)) ? 32'(Q30_ONE) : v;
    sum = 33'(vc) + (33'd1 << (29 - FRAC_BITS));
    return sum[30-FRAC_BITS +: TRIG_W];
  endfunction

  // angle stages
  logic [1:0]  q0_r, q1_r;
  logic [30:0] a0_r, a1_r;
  logic [31:0] a2_r;
  logic [60:0] a_prod;
  logic [61:0] a2_prod;

  assign a_prod  = 61'(phase[29:0]) * 61'(HALF_PI_Q30);
  assign a2_prod = 62'(a0_r) * 62'(a0_r);

  always_ff @(posedge clk) begin
    if (en) begin
      q0_r <= phase[PH_W-1 -: 2];
      a0_r <= a_prod[60:30];
      q1_r <= q0_r;
      a1_r <= a0_r;
      a2_r <= a2_prod[61:30];
    end
  end

  // Horner stages: even stage multiplies by a^2, odd stage divides and subtracts; sine ends with a multiply by a
  logic [31:0] c_r  [HORNER_STAGES];
  logic [31:0] s_r  [HORNER_STAGES];
  logic [30:0] ah_r [HORNER_STAGES];
  logic [31:0] a2h_r[HORNER_STAGES];
  logic [1:0]  qh_r [HORNER_STAGES];

  logic [31:0] c_in  [HORNER_STAGES];
  logic [31:0] s_in  [HORNER_STAGES];
  logic [30:0] a_in  [HORNER_STAGES];
  logic [31:0] a2_in [HORNER_STAGES];
  logic [1:0]  q_in  [HORNER_STAGES];
  logic [31:0] c_nxt [HORNER_STAGES];
  logic [31:0] s_nxt [HORNER_STAGES];

  always_comb begin
    c_in[0]  = 32'(Q30_ONE);
    s_in[0]  = 32'(Q30_ONE);
    a_in[0]  = a1_r;
    a2_in[0] = a2_r;
    q_in[0]  = q1_r;
    for (int st = 1; st < HORNER_STAGES; st++) begin
      c_in[st]  = c_r[st-1];
      s_in[st]  = s_r[st-1];
      a_in[st]  = ah_r[st-1];
      a2_in[st] = a2h_r[st-1];
      q_in[st]  = qh_r[st-1];
    end
  end

  always_comb begin : horner
    logic [63:0] pa;
    logic [63:0] ps;
    logic [64:0] pb;
    logic [64:0] pd;
    int unsigned di;
    for (int st = 0; st < HORNER_STAGES; st++) begin
      if ((st & 1) == 0) begin
        pa        = 64'(c_in[st]) * 64'(a2_in[st]);
        c_nxt[st] = pa[61:30];
      end else begin
        di        = COS_TERMS - 1 - (st >> 1);
        pb        = 65'(c_in[st]) * 65'(COS_M[di]);
        c_nxt[st] = one_minus(32'(pb >> COS_K[di]));
      end
      if (st < 2 * SIN_TERMS) begin
        if ((st & 1) == 0) begin
          ps        = 64'(s_in[st]) * 64'(a2_in[st]);
          s_nxt[st] = ps[61:30];
        end else begin
          di        = SIN_TERMS - 1 - (st >> 1);
          pd        = 65'(s_in[st]) * 65'(SIN_M[di]);
          s_nxt[st] = one_minus(32'(pd >> SIN_K[di]));
        end
      end else if (st == 2 * SIN_TERMS) begin
        // sin(a) = a * series
        ps        = 64'(a_in[st]) * 64'(s_in[st]);
        s_nxt[st] = ps[61:30];
      end else begin
        s_nxt[st] = s_in[st];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < HORNER_STAGES; st++) begin
        c_r[st]   <= c_nxt[st];
        s_r[st]   <= s_nxt[st];
        ah_r[st]  <= a_in[st];
        a2h_r[st] <= a2_in[st];
        qh_r[st]  <= q_in[st];
      end
    end
  end

  // round and fold into the quadrant
  logic [TRIG_W-1:0] sf, cf;
  trig_t             trig_nxt;
  trig_t             trig_r;

  assign sf = to_frac(s_r[HORNER_STAGES-1]);
  assign cf = to_frac(c_r[HORNER_STAGES-1]);

  always_comb begin
    case (quad_t'(qh_r[HORNER_STAGES-1]))
      QUAD_0: trig_nxt = '{sin_mag: sf, sin_neg: 1'b0, cos_mag: cf, cos_neg: 1'b0};
      QUAD_1: trig_nxt = '{sin_mag: cf, sin_neg: 1'b0, cos_mag: sf, cos_neg: 1'b1};
      QUAD_2: trig_nxt = '{sin_mag: sf, sin_neg: 1'b1, cos_mag: cf, cos_neg: 1'b1};
      default: trig_nxt = '{sin_mag: cf, sin_neg: 1'b1, cos_mag: sf, cos_neg: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

// ----- rtl/core/uvs_scale.sv -----
// ----------------------------------------------------------------------------
// uvs_scale
// Scales the trig products by the radius, rounds, and applies signs.
// ----------------------------------------------------------------------------
module uvs_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic [uvs_pkg::RAD_W-1:0]         radius,
  input  uvs_pkg::trig_t                    phi,
  input  uvs_pkg::trig_t                    theta,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_z
);
  import uvs_pkg::*;

  localparam int unsigned P1_W = RAD_W + TRIG_W;
  localparam int unsigned P2_W = P1_W + TRIG_W;
  localparam int unsigned XZ_SHIFT = 2 * FRAC_BITS;

  logic [P1_W-1:0]   px_r, py_r, pz_r;
  logic [TRIG_W-1:0] sp_r;
  logic              xneg_r, yneg_r, zneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= P1_W'(radius) * P1_W'(theta.cos_mag);
      pz_r   <= P1_W'(radius) * P1_W'(theta.sin_mag);
      py_r   <= P1_W'(radius) * P1_W'(phi.cos_mag);
      sp_r   <= phi.sin_mag;
      xneg_r <= theta.cos_neg ^ phi.sin_neg;
      zneg_r <= theta.sin_neg ^ phi.sin_neg;
      yneg_r <= phi.cos_neg;
    end
  end

  logic [P2_W-1:0]  xs, zs;
  logic [P1_W:0]    ys;
  logic [POS_W-1:0] xm, ym, zm;

  // round half up on magnitudes
  assign xs = P2_W'(px_r) * P2_W'(sp_r) + (P2_W'(1) << (XZ_SHIFT - 1));
  assign zs = P2_W'(pz_r) * P2_W'(sp_r) + (P2_W'(1) << (XZ_SHIFT - 1));
  assign ys = (P1_W+1)'(py_r) + ((P1_W+1)'(1) << (FRAC_BITS - 1));
  assign xm = xs[XZ_SHIFT +: POS_W];
  assign zm = zs[XZ_SHIFT +: POS_W];
  assign ym = ys[FRAC_BITS +: POS_W];

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= $signed(xneg_r ? (POS_W'(0) - xm) : xm);
      pos_y <= $signed(yneg_r ? (POS_W'(0) - ym) : ym);
      pos_z <= $signed(zneg_r ? (POS_W'(0) - zm) : zm);
    end
  end

endmodule

// ----- rtl/core/uv_sphere_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// One UV sphere grid point in, its Q8.8 position and six mesh indices out.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    stack_index, slice_index
//   out_ch   out  valid / ready    pos_x/y/z, tri_valid, index_a..index_f
//   cfg_*    in   cfg_we           cfg_idx selects radius, stacks, slices
//
// One item per cycle sustained while the output queue is not full.
// Depth is set by the 8-stage phase divider (4 quotient bits a stage), the
// 14-stage Horner chain of the trig unit and the two radius multiplies.
// All stages advance together; a 2-entry output queue absorbs the tail, and
// in_ch.ready drops only while that queue is full. Nothing is dropped.
// Reset (synchronous, rst_n low) empties the pipe and queue and restores the
// radius to 1.0 and both counts to 16.
//
// Stage map: 0 input/clamp, 1..8 divider, 9..25 trig, 26..27 scale.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  uvs_in_if.sink                           in_ch,
  uvs_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import uvs_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] stacks_cfg_r;
  logic [CNT_W-1:0] slices_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RADIUS_RST;
      stacks_cfg_r <= STACKS_RST;
      slices_cfg_r <= SLICES_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_RADIUS: radius_r     <= cfg_wdata[RAD_W-1:0];
        CFG_STACKS: stacks_cfg_r <= cfg_wdata[CNT_W-1:0];
        CFG_SLICES: slices_cfg_r <= cfg_wdata[CNT_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // zero count behaves as one; cap at the division limit
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] v;
    v = c;
    if (v == '0) v = CNT_W'(1);
    if (32'(v) > MAX_DIVISIONS) v = CNT_W'(MAX_DIVISIONS);
    return v;
  endfunction

  logic [CNT_W-1:0] stacks, slices;
  assign stacks = clamp_count(stacks_cfg_r);
  assign slices = clamp_count(slices_cfg_r);

  // --------------------------------------------------------------------------
  // Flow control: one enable for the whole pipe, gated by queue space
  // --------------------------------------------------------------------------
  logic [1:0]          cnt_r;
  logic                en;
  logic [LAST_STAGE:0] v_r;

  assign en          = ~cnt_r[1];
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST_STAGE-1:0], in_ch.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: clamp grid indices
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] i_r, j_r;

  always_ff @(posedge clk) begin
    if (en) begin
      i_r <= (in_ch.stack_index > stacks) ? stacks : in_ch.stack_index;
      j_r <= (in_ch.slice_index > slices) ? slices : in_ch.slice_index;
    end
  end

  // --------------------------------------------------------------------------
  // Mesh indices: vertex number, then corners, then a delay line
  // --------------------------------------------------------------------------
  logic [VTX_W-1:0] k_r, lim_r;
  idx_t             idx_r [2:LAST_STAGE];

  always_ff @(posedge clk) begin
    if (en) begin
      k_r   <= VTX_W'(VTX_W'(i_r) * (VTX_W'(slices) + VTX_W'(1))) + VTX_W'(j_r);
      lim_r <= VTX_W'(VTX_W'(slices) * (VTX_W'(stacks) + VTX_W'(1)));
      idx_r[2] <= '{tri_valid: (k_r < lim_r),
                    index_a:   k_r,
                    index_b:   k_r + VTX_W'(slices) + VTX_W'(1),
                    index_c:   k_r + VTX_W'(slices),
                    index_d:   k_r + VTX_W'(slices) + VTX_W'(1),
                    index_e:   k_r,
                    index_f:   k_r + VTX_W'(1)};
      for (int s = 3; s <= LAST_STAGE; s++) begin
        idx_r[s] <= idx_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Angles: phi = i / (2 stacks) turn, theta = j / slices turn
  // --------------------------------------------------------------------------
  logic [PH_W-1:0] phase_phi, phase_theta;
  trig_t           trig_phi, trig_theta;

  uvs_div u_div_phi (
    .clk   (clk),
    .en    (en),
    .num   (i_r),
    .den   ({stacks, 1'b0}),
    .phase (phase_phi)
  );

  uvs_div u_div_theta (
    .clk   (clk),
    .en    (en),
    .num   (j_r),
    .den   ({1'b0, slices}),
    .phase (phase_theta)
  );

  uvs_trig u_trig_phi (
    .clk   (clk),
    .en    (en),
    .phase (phase_phi),
    .trig  (trig_phi)
  );

  uvs_trig u_trig_theta (
    .clk   (clk),
    .en    (en),
    .phase (phase_theta),
    .trig  (trig_theta)
  );

  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;

  uvs_scale u_scale (
    .clk    (clk),
    .en     (en),
    .radius (radius_r),
    .phi    (trig_phi),
    .theta  (trig_theta),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .pos_z  (pos_z)
  );

  // --------------------------------------------------------------------------
  // Output queue, two entries
  // --------------------------------------------------------------------------
  out_item_t fifo_r [2];
  logic      wr_ptr_r, rd_ptr_r;
  logic      push, pop;
  logic [1:0] cnt_nxt;
  out_item_t head;

  assign push = en & v_r[LAST_STAGE];
  assign pop  = out_ch.valid & out_ch.ready;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                            idx: idx_r[LAST_STAGE]};
    end
  end

  assign head             = fifo_r[rd_ptr_r];
  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.pos_x     = head.pos_x;
  assign out_ch.pos_y     = head.pos_y;
  assign out_ch.pos_z     = head.pos_z;
  assign out_ch.tri_valid = head.idx.tri_valid;
  assign out_ch.index_a   = head.idx.index_a;
  assign out_ch.index_b   = head.idx.index_b;
  assign out_ch.index_c   = head.idx.index_c;
  assign out_ch.index_d   = head.idx.index_d;
  assign out_ch.index_e   = head.idx.index_e;
  assign out_ch.index_f   = head.idx.index_f;

endmodule

// ----- rtl/core/uvs_checker.sv -----
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks on the vertex generator, attached by bind.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_assert.svh"

module uvs_checker (
  input logic       clk,
  input logic       rst_n,
  uvs_in_if.sink    in_ch,
  uvs_out_if.source out_ch
);

  // input backpressure only when a full queue is waiting at the output
  `UVS_ASSERT_SAME(a_stall_has_out, clk, rst_n, !in_ch.ready, out_ch.valid)

  `UVS_ASSERT_SAME(a_dup_corners, clk, rst_n, out_ch.valid, (out_ch.index_a == out_ch.index_e) && (out_ch.index_b == out_ch.index_d))

  `UVS_ASSERT_SAME(a_corner_step, clk, rst_n, out_ch.valid, (out_ch.index_b == 17'(out_ch.index_c + 17'd1)) && (out_ch.index_f == 17'(out_ch.index_a + 17'd1)))

  `UVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.pos_x) && $stable(out_ch.index_a))

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
